// ----- rtl/core/rgb565_pkg.sv -----
// Types, register indexes and channel expansion helpers for the RGB565 tinted blend.
`default_nettype none

package rgb565_pkg;

  typedef struct packed {
    logic [15:0] dest_pixel;
    logic [7:0]  glyph_alpha;
    logic [9:0]  strength;
  } rgb565_in_t;

  typedef struct packed {
    logic [15:0] blended_pixel;
    logic        write_enable;
  } rgb565_out_t;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TINT_RED   = 2'd0,
    REG_TINT_GREEN = 2'd1,
    REG_TINT_BLUE  = 2'd2
  } rgb565_reg_t;

  localparam logic [7:0] TINT_RED_RST   = 8'd40;
  localparam logic [7:0] TINT_GREEN_RST = 8'd90;
  localparam logic [7:0] TINT_BLUE_RST  = 8'd140;

  // c * 255 / 31 = 8c + floor(7c / 31); 7c / 31 via reciprocal 265 / 2^13 (exact for 7c <= 217)
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [7:0]  c7;
    logic [15:0] prod;
    c7   = {c, 3'b000} - {3'b000, c};
    prod = 16'(c7) * 16'd265;
    return {c, 3'b000} + {5'b00000, prod[15:13]};
  endfunction

  // c * 255 / 63 = 4c + floor(c / 21)
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [1:0] q;
    q = (c >= 6'd63) ? 2'd3 : (c >= 6'd42) ? 2'd2 : (c >= 6'd21) ? 2'd1 : 2'd0;
    return {c, 2'b00} + {6'b000000, q};
  endfunction

  // x / 255 for x <= 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rgb565_tinted_alpha_blend.sv -----
// Top level: four-stage pipelined tinted alpha blend of RGB565 pixels.
`default_nettype none

//  channel | ports                                  | carries
//  --------+----------------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data            | dest pixel, glyph alpha, strength
//  out     | out_valid, out_ready, out_data         | blended pixel, write flag
//  cfg     | cfg_wr_en, cfg_index, cfg_data         | tint red / green / blue writes
//
//  out_valid rises once an accepted request has passed stages 1 to 4, and the result
//  handshake follows. One request per cycle sustained while out_ready stays high.
//  The stages are alpha multiply, scale and saturate, channel multiply-adds and /255.
//  rst_n (sync, active low) clears all stage valids and reloads the default tint.
//  Each stage advances when it is empty or the stage after it moves, so bubbles are
//  squeezed out under back-pressure and nothing is dropped or repeated.

module rgb565_tinted_alpha_blend
  import rgb565_pkg::*;
#(
  parameter int unsigned INTENSITY_FRAC_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire rgb565_in_t           in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rgb565_out_t               out_data,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  localparam int unsigned PROD_W = 18;  // 8-bit alpha times 10-bit strength

  // ---------------- tint registers ----------------
  logic [7:0] tint_red_r, tint_green_r, tint_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tint_red_r   <= TINT_RED_RST;
      tint_green_r <= TINT_GREEN_RST;
      tint_blue_r  <= TINT_BLUE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TINT_RED:   tint_red_r   <= cfg_data;
        REG_TINT_GREEN: tint_green_r <= cfg_data;
        REG_TINT_BLUE:  tint_blue_r  <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------- stage advance ----------------
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic en1, en2, en3, en4;

  assign en4      = !s4_v_r || out_ready;
  assign en3      = !s3_v_r || en4;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (en1) s1_v_r <= in_valid;
      if (en2) s2_v_r <= s1_v_r;
      if (en3) s3_v_r <= s2_v_r;
      if (en4) s4_v_r <= s3_v_r;
    end
  end

  // ---------------- stage 1: alpha x strength, widen channels ----------------
  logic [PROD_W-1:0] s1_prod_r;
  logic [15:0]       s1_pix_r;
  logic [7:0]        s1_dr_r, s1_dg_r, s1_db_r;

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_prod_r <= PROD_W'(in_data.glyph_alpha) * PROD_W'(in_data.strength);
      s1_pix_r  <= in_data.dest_pixel;
      s1_dr_r   <= expand5(in_data.dest_pixel[15:11]);
      s1_dg_r   <= expand6(in_data.dest_pixel[10:5]);
      s1_db_r   <= expand5(in_data.dest_pixel[4:0]);
    end
  end

  // ---------------- stage 2: scale down, saturate ----------------
  logic [PROD_W-1:0] shifted;
  logic [7:0]        a_nxt;

  assign shifted = s1_prod_r >> INTENSITY_FRAC_BITS;
  // intensity above one only when the fraction is narrower than the strength field
  assign a_nxt   = (|shifted[PROD_W-1:8]) ? 8'd255 : shifted[7:0];

  logic [7:0]  s2_a_r;
  logic        s2_we_r;
  logic [15:0] s2_pix_r;
  logic [7:0]  s2_dr_r, s2_dg_r, s2_db_r;

  always_ff @(posedge clk) begin
    if (en2 && s1_v_r) begin
      s2_a_r   <= a_nxt;
      s2_we_r  <= (a_nxt != 8'd0);
      s2_pix_r <= s1_pix_r;
      s2_dr_r  <= s1_dr_r;
      s2_dg_r  <= s1_dg_r;
      s2_db_r  <= s1_db_r;
    end
  end

  // ---------------- stage 3: tint*a + dst*(255-a), one lane per channel ----------------
  logic [7:0] inv_a;
  assign inv_a = ~s2_a_r;  // 255 - a

  logic [15:0] s3_sr_r, s3_sg_r, s3_sb_r;
  logic        s3_we_r;
  logic [15:0] s3_pix_r;

  always_ff @(posedge clk) begin
    if (en3 && s2_v_r) begin
      s3_sr_r  <= 16'(tint_red_r)   * 16'(s2_a_r) + 16'(s2_dr_r) * 16'(inv_a);
      s3_sg_r  <= 16'(tint_green_r) * 16'(s2_a_r) + 16'(s2_dg_r) * 16'(inv_a);
      s3_sb_r  <= 16'(tint_blue_r)  * 16'(s2_a_r) + 16'(s2_db_r) * 16'(inv_a);
      s3_we_r  <= s2_we_r;
      s3_pix_r <= s2_pix_r;
    end
  end

  // ---------------- stage 4: /255, repack, output register ----------------
  logic [7:0] nr, ng, nb;
  assign nr = div255(s3_sr_r);
  assign ng = div255(s3_sg_r);
  assign nb = div255(s3_sb_r);

  rgb565_out_t s4_out_r;

  always_ff @(posedge clk) begin
    if (en4 && s3_v_r) begin
      s4_out_r.write_enable  <= s3_we_r;
      // zero alpha passes the pixel untouched
      s4_out_r.blended_pixel <= s3_we_r ? {nr[7:3], ng[7:2], nb[7:3]} : s3_pix_r;
    end
  end

  assign out_valid = s4_v_r;
  assign out_data  = s4_out_r;

endmodule

`default_nettype wire
